FILE: rtl/first_fit_heap_allocator_defines.svh
// ---------------------------------------------------------------------------
// first_fit_heap_allocator_defines
// Assertion macros shared by the checker of the heap allocator.
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FFA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/ffa_pkg.sv
// ---------------------------------------------------------------------------
// ffa_pkg
// Field widths, result codes, state encodings and the command and status
// bundles shared by the heap allocator modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffa_pkg;

	// Payload field widths.
	localparam int unsigned OP_W     = 1;
	localparam int unsigned REQ_W    = 13;
	localparam int unsigned OFF_W    = 12;
	localparam int unsigned STATUS_W = 3;

	// Operation codes.
	localparam logic [OP_W-1:0] OPER_ALLOC = 1'b0;
	localparam logic [OP_W-1:0] OPER_FREE  = 1'b1;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK           = 3'd0,
		ST_ZERO_SIZE    = 3'd1,
		ST_NO_FIT       = 3'd2,
		ST_NULL_IGNORED = 3'd3,
		ST_INVALID      = 3'd4,
		ST_DOUBLE_FREE  = 3'd5
	} status_t;

	// Datapath operations, one per controller step.
	typedef enum logic [4:0] {
		DP_IDLE,
		DP_INIT,
		DP_DECODE,
		DP_A_READ,
		DP_A_CHECK,
		DP_A_CARVE,
		DP_A_LINK,
		DP_F_READ,
		DP_F_CHECK,
		DP_F_TARGET,
		DP_F_MARK,
		DP_F_NEXT,
		DP_F_NEXT_LINK,
		DP_F_UL_READ,
		DP_F_UL_CHECK,
		DP_F_PREV,
		DP_F_MERGE,
		DP_FINISH
	} dp_op_t;

	// Controller states.
	typedef enum logic [4:0] {
		S_INIT,
		S_IDLE,
		S_DECODE,
		S_A_READ,
		S_A_CHECK,
		S_A_CARVE,
		S_A_LINK,
		S_F_READ,
		S_F_CHECK,
		S_F_TARGET,
		S_F_MARK,
		S_F_NEXT,
		S_F_NEXT_LINK,
		S_F_UL_READ,
		S_F_UL_CHECK,
		S_F_PREV,
		S_F_MERGE,
		S_FINISH
	} ffa_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		dp_op_t  op;
		logic    in_ready;
		logic    res_set;
		status_t res_code;
		logic    out_load;
	} ffa_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic    in_fire;
		logic    is_free;
		logic    dec_err;
		status_t dec_code;
		logic    walk_ok;
		logic    a_fit;
		logic    f_cont;
		logic    f_hit;
		logic    f_bad;
		logic    f_dbl;
		logic    f_nb_in;
		logic    f_nb_free;
		logic    f_head_hit;
		logic    ul_hit;
		logic    has_prev;
		logic    out_free;
	} ffa_stat_t;

endpackage

FILE: rtl/ffa_if.sv
// ---------------------------------------------------------------------------
// ffa_req_if / ffa_rsp_if
// Valid/ready channels carrying allocator requests and responses.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ffa_req_if;
	import ffa_pkg::*;

	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    operation;
	logic [REQ_W-1:0]   request_bytes;
	logic [OFF_W-1:0]   free_offset;
	logic               null_pointer;

	modport source (output valid, output operation, output request_bytes,
		output free_offset, output null_pointer, input ready);
	modport sink (input valid, input operation, input request_bytes,
		input free_offset, input null_pointer, output ready);
endinterface

interface ffa_rsp_if;
	import ffa_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [OFF_W-1:0]    user_offset;

	modport source (output valid, output status, output user_offset, input ready);
	modport sink (input valid, input status, input user_offset, output ready);
endinterface

FILE: rtl/ffa_datapath.sv
// ---------------------------------------------------------------------------
// ffa_datapath
// Header stores, free-list head, walk registers and the response register.
// Executes one operation per cycle as commanded by the controller.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffa_datapath #(
	parameter int unsigned HEAP_BYTES   = 4096,
	parameter int unsigned ALIGN_BYTES  = 8,
	parameter int unsigned HEADER_BYTES = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ffa_pkg::ffa_cmd_t          cmd,
	output ffa_pkg::ffa_stat_t         stat,
	input  logic                       in_fire,
	input  logic [ffa_pkg::OP_W-1:0]   operation,
	input  logic [ffa_pkg::REQ_W-1:0]  request_bytes,
	input  logic [ffa_pkg::OFF_W-1:0]  free_offset,
	input  logic                       null_pointer,
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic [ffa_pkg::STATUS_W-1:0] status,
	output logic [ffa_pkg::OFF_W-1:0]  user_offset
);
	import ffa_pkg::*;

	localparam int unsigned GRANULES = HEAP_BYTES / ALIGN_BYTES;
	localparam int unsigned GW       = $clog2(GRANULES);
	localparam int unsigned LW       = $clog2(GRANULES + 1);
	localparam int unsigned SW       = $clog2(HEAP_BYTES + 1);
	localparam int unsigned PW       = SW + 1;
	localparam int unsigned CW       = $clog2(GRANULES + 2);
	localparam int unsigned AB       = $clog2(ALIGN_BYTES);
	localparam int unsigned HDR_SPAN =
		((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
	localparam int unsigned MIN_REM  = HDR_SPAN + ALIGN_BYTES;
	localparam int unsigned TW       = REQ_W + 1;
	localparam int unsigned CMPW     = ((SW > TW) ? SW : TW) + 1;

	// Header stores, one entry per granule.
	logic [SW-1:0] size_mem [GRANULES];
	logic          mark_mem [GRANULES];
	logic [LW-1:0] link_mem [GRANULES];

	// Captured item and walk state.
	logic [OP_W-1:0]  op_q;
	logic [REQ_W-1:0] req_q;
	logic [OFF_W-1:0] off_q;
	logic             null_q;
	logic [TW-1:0]    total_q;
	logic [LW-1:0]    cur_q, prev_q, after_q, nl_q, head_q;
	logic [CW-1:0]    steps_q;
	logic [PW-1:0]    pos_q;
	logic [OFF_W-1:0] bbyte_q;
	logic [GW-1:0]    g_q, prev_g_q, ng_q;
	logic             split_q, has_prev_q;
	logic [SW-1:0]    szg_q;
	logic [SW-1:0]    sz_rd_q;
	logic             mark_rd_q;
	logic [LW-1:0]    link_rd_q;
	status_t          res_status_q;
	logic [OFF_W-1:0] uoff_q;
	logic             out_valid_q;
	status_t          out_status_q;
	logic [OFF_W-1:0] out_uoff_q;

	// Combinational helpers.
	logic [TW-1:0]    rounded_c, total_c;
	logic [OFF_W-1:0] bbyte_c;
	logic [GW-1:0]    g_c, cur_g, pg_c, rg_c, ng_c;
	logic             a_fit_c, split_c, f_bad_c, adj_c;
	logic [PW-1:0]    pos_end_c, nb_c;
	logic [LW-1:0]    target_c;
	status_t          dec_code_c;
	logic             dec_err_c;
	logic [GW-1:0]    raddr;
	logic             size_we, mark_we, link_we;
	logic [GW-1:0]    size_wa, mark_wa, link_wa;
	logic [SW-1:0]    size_wd;
	logic             mark_wd;
	logic [LW-1:0]    link_wd;

	// Request decode: rounded size and header position of a freed pointer.
	always_comb begin
		rounded_c = TW'(req_q) + TW'(ALIGN_BYTES - 1);
		rounded_c = (rounded_c >> AB) << AB;
		total_c   = rounded_c + TW'(HDR_SPAN);
		bbyte_c   = off_q - OFF_W'(HDR_SPAN);
		g_c       = GW'(bbyte_c >> AB);
		dec_err_c  = 1'b0;
		dec_code_c = ST_OK;
		if (op_q == OPER_ALLOC) begin
			if (req_q == '0) begin
				dec_err_c  = 1'b1;
				dec_code_c = ST_ZERO_SIZE;
			end
		end else if (null_q) begin
			dec_err_c  = 1'b1;
			dec_code_c = ST_NULL_IGNORED;
		end else if (32'(off_q) < HDR_SPAN || bbyte_c[AB-1:0] != '0 ||
				32'(bbyte_c) >= HEAP_BYTES) begin
			dec_err_c  = 1'b1;
			dec_code_c = ST_INVALID;
		end
	end

	// Walk arithmetic on the registered header reads.
	always_comb begin
		cur_g     = GW'(cur_q - LW'(1));
		a_fit_c   = CMPW'(sz_rd_q) >= CMPW'(total_q);
		split_c   = CMPW'(sz_rd_q) >= CMPW'(total_q) + CMPW'(MIN_REM);
		rg_c      = cur_g + GW'(total_q >> AB);
		pg_c      = GW'(pos_q >> AB);
		pos_end_c = pos_q + PW'(sz_rd_q);
		f_bad_c   = (sz_rd_q == '0) || (32'(pos_end_c) > 32'(bbyte_q));
		adj_c     = (32'(pos_end_c) == 32'(bbyte_q)) && mark_rd_q;
		nb_c      = PW'(bbyte_q) + PW'(sz_rd_q);
		ng_c      = GW'(nb_c >> AB);
		target_c  = LW'(ng_q) + LW'(1);
	end

	// Status toward the controller.
	always_comb begin
		stat.in_fire    = in_fire;
		stat.is_free    = (op_q == OPER_FREE);
		stat.dec_err    = dec_err_c;
		stat.dec_code   = dec_code_c;
		stat.walk_ok    = (cur_q != '0) && (32'(cur_q) <= GRANULES) &&
			(32'(steps_q) <= GRANULES);
		stat.a_fit      = a_fit_c;
		stat.f_cont     = (32'(pos_q) < HEAP_BYTES) && (32'(steps_q) <= GRANULES);
		stat.f_hit      = (32'(pos_q) == 32'(bbyte_q));
		stat.f_bad      = f_bad_c;
		stat.f_dbl      = mark_rd_q;
		stat.f_nb_in    = 32'(nb_c) < HEAP_BYTES;
		stat.f_nb_free  = mark_rd_q;
		stat.f_head_hit = (head_q == target_c);
		stat.ul_hit     = (link_rd_q == target_c);
		stat.has_prev   = has_prev_q;
		stat.out_free   = !out_valid_q || out_ready;
	end

	// Shared read address for the three header stores.
	always_comb begin
		case (cmd.op)
			DP_A_READ, DP_F_UL_READ: raddr = cur_g;
			DP_F_READ:               raddr = pg_c;
			DP_F_MARK:               raddr = ng_c;
			DP_F_NEXT:               raddr = ng_q;
			DP_F_PREV:               raddr = prev_g_q;
			default:                 raddr = g_q;
		endcase
	end

	// Header store write selection.
	always_comb begin
		size_we = 1'b0; size_wa = g_q; size_wd = szg_q;
		mark_we = 1'b0; mark_wa = g_q; mark_wd = 1'b0;
		link_we = 1'b0; link_wa = g_q; link_wd = '0;
		case (cmd.op)
			DP_INIT: begin
				size_we = 1'b1; size_wa = '0; size_wd = SW'(HEAP_BYTES);
				mark_we = 1'b1; mark_wa = '0; mark_wd = 1'b1;
				link_we = 1'b1; link_wa = '0;
			end
			DP_A_CHECK: begin
				if (a_fit_c && split_c) begin
					size_we = 1'b1; size_wa = rg_c;
					size_wd = SW'(CMPW'(sz_rd_q) - CMPW'(total_q));
					mark_we = 1'b1; mark_wa = rg_c; mark_wd = 1'b1;
					link_we = 1'b1; link_wa = rg_c; link_wd = link_rd_q;
				end
			end
			DP_A_CARVE: begin
				size_we = split_q; size_wd = SW'(total_q);
				mark_we = 1'b1;
				link_we = 1'b1;
			end
			DP_A_LINK: begin
				link_we = (prev_q != '0);
				link_wa = GW'(prev_q - LW'(1));
				link_wd = after_q;
			end
			DP_F_MARK: begin
				mark_we = !mark_rd_q; mark_wd = 1'b1;
				link_we = !mark_rd_q;
			end
			DP_F_UL_CHECK: begin
				link_we = (link_rd_q == target_c);
				link_wa = cur_g;
				link_wd = nl_q;
			end
			DP_F_PREV: begin
				size_we = 1'b1;
				link_we = !has_prev_q; link_wd = head_q;
			end
			DP_F_MERGE: begin
				size_we = 1'b1; size_wa = prev_g_q; size_wd = sz_rd_q + szg_q;
			end
			default: begin
			end
		endcase
	end

	// Header stores with registered reads.
	always_ff @(posedge clk) begin
		if (size_we) begin
			size_mem[size_wa] <= size_wd;
		end
		if (mark_we) begin
			mark_mem[mark_wa] <= mark_wd;
		end
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
		sz_rd_q   <= size_mem[raddr];
		mark_rd_q <= mark_mem[raddr];
		link_rd_q <= link_mem[raddr];
	end

	// Item capture and walk registers.
	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_IDLE: begin
				if (in_fire) begin
					op_q   <= operation;
					req_q  <= request_bytes;
					off_q  <= free_offset;
					null_q <= null_pointer;
				end
			end
			DP_DECODE: begin
				total_q    <= total_c;
				cur_q      <= head_q;
				prev_q     <= '0;
				steps_q    <= '0;
				pos_q      <= '0;
				has_prev_q <= 1'b0;
				bbyte_q    <= bbyte_c;
				g_q        <= g_c;
				uoff_q     <= '0;
			end
			DP_A_CHECK: begin
				if (a_fit_c) begin
					g_q     <= cur_g;
					split_q <= split_c;
					after_q <= split_c ? (LW'(rg_c) + LW'(1)) : link_rd_q;
				end else begin
					prev_q  <= cur_q;
					cur_q   <= link_rd_q;
					steps_q <= steps_q + CW'(1);
				end
			end
			DP_A_LINK: begin
				uoff_q <= OFF_W'((32'(g_q) << AB) + HDR_SPAN);
			end
			DP_F_CHECK: begin
				if (!f_bad_c) begin
					has_prev_q <= adj_c;
					prev_g_q   <= pg_c;
					pos_q      <= pos_end_c;
					steps_q    <= steps_q + CW'(1);
				end
			end
			DP_F_MARK: begin
				szg_q <= sz_rd_q;
				ng_q  <= ng_c;
			end
			DP_F_NEXT: begin
				if (mark_rd_q) begin
					szg_q <= szg_q + sz_rd_q;
				end
			end
			DP_F_NEXT_LINK: begin
				nl_q    <= link_rd_q;
				cur_q   <= head_q;
				steps_q <= '0;
			end
			DP_F_UL_CHECK: begin
				if (link_rd_q != target_c) begin
					cur_q   <= link_rd_q;
					steps_q <= steps_q + CW'(1);
				end
			end
			default: begin
			end
		endcase
		if (cmd.res_set) begin
			res_status_q <= cmd.res_code;
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_uoff_q   <= uoff_q;
		end
	end

	// Free-list head and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= LW'(1);
			out_valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				DP_A_LINK: begin
					if (prev_q == '0) begin
						head_q <= after_q;
					end
				end
				DP_F_NEXT_LINK: begin
					if (head_q == target_c) begin
						head_q <= link_rd_q;
					end
				end
				DP_F_PREV: begin
					if (!has_prev_q) begin
						head_q <= LW'(g_q) + LW'(1);
					end
				end
				default: begin
				end
			endcase
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign user_offset = out_uoff_q;
endmodule

FILE: rtl/ffa_controller.sv
// ---------------------------------------------------------------------------
// ffa_controller
// Sequencer for allocate and free: steps the datapath through the list and
// block walks and decides the result status.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffa_controller (
	input  logic               clk,
	input  logic               arst_n,
	input  ffa_pkg::ffa_stat_t stat,
	output ffa_pkg::ffa_cmd_t  cmd
);
	import ffa_pkg::*;

	ffa_state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT:     state_d = S_IDLE;
			S_IDLE:     if (stat.in_fire) state_d = S_DECODE;
			S_DECODE: begin
				if (stat.dec_err) state_d = S_FINISH;
				else if (stat.is_free) state_d = S_F_READ;
				else state_d = S_A_READ;
			end
			S_A_READ:   state_d = stat.walk_ok ? S_A_CHECK : S_FINISH;
			S_A_CHECK:  state_d = stat.a_fit ? S_A_CARVE : S_A_READ;
			S_A_CARVE:  state_d = S_A_LINK;
			S_A_LINK:   state_d = S_FINISH;
			S_F_READ: begin
				if (!stat.f_cont) state_d = S_FINISH;
				else if (stat.f_hit) state_d = S_F_TARGET;
				else state_d = S_F_CHECK;
			end
			S_F_CHECK:  state_d = stat.f_bad ? S_FINISH : S_F_READ;
			S_F_TARGET: state_d = S_F_MARK;
			S_F_MARK: begin
				if (stat.f_dbl) state_d = S_FINISH;
				else if (stat.f_nb_in) state_d = S_F_NEXT;
				else state_d = S_F_PREV;
			end
			S_F_NEXT:      state_d = stat.f_nb_free ? S_F_NEXT_LINK : S_F_PREV;
			S_F_NEXT_LINK: state_d = stat.f_head_hit ? S_F_PREV : S_F_UL_READ;
			S_F_UL_READ:   state_d = stat.walk_ok ? S_F_UL_CHECK : S_F_PREV;
			S_F_UL_CHECK:  state_d = stat.ul_hit ? S_F_PREV : S_F_UL_READ;
			S_F_PREV:      state_d = stat.has_prev ? S_F_MERGE : S_FINISH;
			S_F_MERGE:     state_d = S_FINISH;
			S_FINISH:      if (stat.out_free) state_d = S_IDLE;
			default:       state_d = S_INIT;
		endcase
	end

	// Commands for the current state.
	always_comb begin
		cmd.op       = DP_IDLE;
		cmd.in_ready = 1'b0;
		cmd.res_set  = 1'b0;
		cmd.res_code = ST_OK;
		cmd.out_load = 1'b0;
		case (state_q)
			S_INIT: cmd.op = DP_INIT;
			S_IDLE: begin
				cmd.op       = DP_IDLE;
				cmd.in_ready = 1'b1;
			end
			S_DECODE: begin
				cmd.op       = DP_DECODE;
				cmd.res_set  = stat.dec_err;
				cmd.res_code = stat.dec_code;
			end
			S_A_READ: begin
				cmd.op       = DP_A_READ;
				cmd.res_set  = !stat.walk_ok;
				cmd.res_code = ST_NO_FIT;
			end
			S_A_CHECK: cmd.op = DP_A_CHECK;
			S_A_CARVE: cmd.op = DP_A_CARVE;
			S_A_LINK: begin
				cmd.op       = DP_A_LINK;
				cmd.res_set  = 1'b1;
				cmd.res_code = ST_OK;
			end
			S_F_READ: begin
				cmd.op       = DP_F_READ;
				cmd.res_set  = !stat.f_cont;
				cmd.res_code = ST_INVALID;
			end
			S_F_CHECK: begin
				cmd.op       = DP_F_CHECK;
				cmd.res_set  = stat.f_bad;
				cmd.res_code = ST_INVALID;
			end
			S_F_TARGET: cmd.op = DP_F_TARGET;
			S_F_MARK: begin
				cmd.op       = DP_F_MARK;
				cmd.res_set  = stat.f_dbl;
				cmd.res_code = ST_DOUBLE_FREE;
			end
			S_F_NEXT:      cmd.op = DP_F_NEXT;
			S_F_NEXT_LINK: cmd.op = DP_F_NEXT_LINK;
			S_F_UL_READ:   cmd.op = DP_F_UL_READ;
			S_F_UL_CHECK:  cmd.op = DP_F_UL_CHECK;
			S_F_PREV: begin
				cmd.op       = DP_F_PREV;
				cmd.res_set  = 1'b1;
				cmd.res_code = ST_OK;
			end
			S_F_MERGE: cmd.op = DP_F_MERGE;
			S_FINISH: begin
				cmd.op       = DP_FINISH;
				cmd.out_load = stat.out_free;
			end
			default: cmd.op = DP_IDLE;
		endcase
	end
endmodule

FILE: rtl/first_fit_heap_allocator.sv
// First-fit heap allocator with coalescing. One item is worked at a time;
// a new item is taken once the previous one has reached the response
// register, even if that response is still waiting to be taken. Allocate
// walks the free list, reading and checking each entry in turn. Free walks
// the blocks in address order up to the freed one, looks at the block
// that follows when there is one, unlinks that block from the free list,
// walking the list, when it merges with it, and merges with the block
// before when that one is free. The header stores have a single shared
// read port. After reset the block writes the initial header before it
// takes its first item.
// ALIGN_BYTES must be a power of two.
// ---------------------------------------------------------------------------
// first_fit_heap_allocator
// Top level: joins the controller and the datapath to the request and
// response channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module first_fit_heap_allocator #(
	parameter int unsigned HEAP_BYTES   = 4096,
	parameter int unsigned ALIGN_BYTES  = 8,
	parameter int unsigned HEADER_BYTES = 24
) (
	input logic   clk,
	input logic   arst_n,
	ffa_req_if.sink   request,
	ffa_rsp_if.source response
);
	import ffa_pkg::*;

	ffa_cmd_t  cmd;
	ffa_stat_t stat;
	logic      in_fire;

	// Request handshake.
	assign request.ready = cmd.in_ready;
	assign in_fire       = request.valid && cmd.in_ready;

	ffa_controller u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	ffa_datapath #(
		.HEAP_BYTES   (HEAP_BYTES),
		.ALIGN_BYTES  (ALIGN_BYTES),
		.HEADER_BYTES (HEADER_BYTES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.in_fire       (in_fire),
		.operation     (request.operation),
		.request_bytes (request.request_bytes),
		.free_offset   (request.free_offset),
		.null_pointer  (request.null_pointer),
		.out_ready     (response.ready),
		.out_valid     (response.valid),
		.status        (response.status),
		.user_offset   (response.user_offset)
	);
endmodule

FILE: rtl/ffa_checker.sv
// ---------------------------------------------------------------------------
// ffa_checker
// Port-level checks of the heap allocator, bound to its top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "first_fit_heap_allocator_defines.svh"

module ffa_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_ready,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic [ffa_pkg::STATUS_W-1:0]   rsp_status,
	input logic [ffa_pkg::OFF_W-1:0]      rsp_user_offset
);
	import ffa_pkg::*;

	// A pending response stays offered until it is taken.
	`FFA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped")

	// Only defined result codes leave the block.
	`FFA_ASSERT_SAME(a_status_range, rsp_valid, rsp_status <= ST_DOUBLE_FREE, "bad status")

	// Only a successful allocate reports a nonzero offset.
	`FFA_ASSERT_SAME(a_offset_zero, rsp_valid && rsp_status != ST_OK, rsp_user_offset == '0, "offset on failure")

	// One item at a time: the request side closes right after an accept.
	`FFA_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "second item taken")
endmodule

bind first_fit_heap_allocator ffa_checker u_ffa_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (request.valid),
	.req_ready       (request.ready),
	.rsp_valid       (response.valid),
	.rsp_ready       (response.ready),
	.rsp_status      (response.status),
	.rsp_user_offset (response.user_offset)
);

FILE: tb/sv/first_fit_heap_allocator_tb.sv
// ---------------------------------------------------------------------------
// first_fit_heap_allocator_tb
// Drives allocate and free items into the heap allocator, predicts each
// response with a behavioral model of the heap and compares every response
// field by field, under random idling on both channels and stall pressure.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module first_fit_heap_allocator_tb;
	import ffa_pkg::*;

	localparam int unsigned HEAP     = 4096;
	localparam int unsigned GRAIN    = 8;
	localparam int unsigned GRAN     = HEAP / GRAIN;
	localparam int unsigned HDR      = 24;
	localparam int unsigned MIN_REM  = HDR + GRAIN;
	localparam int unsigned STALL_LIMIT = 20000;
	localparam int unsigned HOLD_CYCLES = 400;

	typedef struct {
		logic [OP_W-1:0]  op;
		logic [REQ_W-1:0] req;
		logic [OFF_W-1:0] off;
		logic             nul;
		status_t          st;
		logic [OFF_W-1:0] uoff;
	} heap_item_t;

	logic clk;
	logic arst_n;

	ffa_req_if req_ch ();
	ffa_rsp_if rsp_ch ();

	first_fit_heap_allocator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (req_ch),
		.response (rsp_ch)
	);

	// Shadow copy of the heap headers.
	logic [12:0] hdr_size [GRAN];
	bit          hdr_free [GRAN];
	logic [9:0]  hdr_link [GRAN];
	int unsigned list_head;

	heap_item_t  pending_q [$];
	heap_item_t  response_q [$];
	heap_item_t  in_flight;
	int unsigned live_offs [$];
	int unsigned dead_offs [$];

	int unsigned src_idle_pct;
	int unsigned dst_idle_pct;
	bit          hold_go;
	bit          hold_done;
	int unsigned hold_cnt;
	int unsigned err_cnt;
	int unsigned quiet_cycles;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Removes a free block from the free list.
	function automatic void list_unlink(int unsigned g);
		int unsigned tgt, cur, nxt, steps;
		tgt = g + 1;
		cur = list_head;
		steps = 0;
		if (cur == tgt) begin
			list_head = hdr_link[g];
			return;
		end
		while (cur != 0 && cur <= GRAN && steps <= GRAN) begin
			nxt = hdr_link[cur-1];
			if (nxt == tgt) begin
				hdr_link[cur-1] = hdr_link[g];
				return;
			end
			cur = nxt;
			steps++;
		end
	endfunction

	// First-fit allocation on the shadow heap.
	function automatic void heap_alloc(int unsigned req, ref heap_item_t it);
		int unsigned total, prev, cur, steps, g, after, r;
		prev = 0;
		cur = list_head;
		steps = 0;
		it.uoff = '0;
		if (req == 0) begin
			it.st = ST_ZERO_SIZE;
			return;
		end
		total = HDR + ((req + GRAIN - 1) / GRAIN) * GRAIN;
		while (cur != 0 && cur <= GRAN && steps <= GRAN) begin
			g = cur - 1;
			if (hdr_size[g] >= total) begin
				after = hdr_link[g];
				if (hdr_size[g] >= total + MIN_REM) begin
					r = g + total / GRAIN;
					hdr_size[r] = 13'(hdr_size[g] - total);
					hdr_free[r] = 1'b1;
					hdr_link[r] = 10'(after);
					hdr_size[g] = 13'(total);
					after = r + 1;
				end
				if (prev == 0)
					list_head = after;
				else
					hdr_link[prev-1] = 10'(after);
				hdr_free[g] = 1'b0;
				hdr_link[g] = '0;
				it.uoff = OFF_W'(g * GRAIN + HDR);
				it.st = ST_OK;
				return;
			end
			prev = cur;
			cur = hdr_link[g];
			steps++;
		end
		it.st = ST_NO_FIT;
	endfunction

	// Release with coalescing on the shadow heap.
	function automatic status_t heap_release(int unsigned off);
		int unsigned bbyte, g, pos, steps, pg, sz, nb, ng, prev_g;
		bit found, has_prev, stop;
		pos = 0;
		steps = 0;
		prev_g = 0;
		found = 0;
		has_prev = 0;
		stop = 0;
		if (off < HDR)
			return ST_INVALID;
		bbyte = off - HDR;
		if ((bbyte % GRAIN) != 0 || bbyte >= HEAP)
			return ST_INVALID;
		g = bbyte / GRAIN;
		// Walk the blocks in address order up to the freed one.
		while (!stop && pos < HEAP && steps <= GRAN) begin
			pg = pos / GRAIN;
			sz = hdr_size[pg];
			if (pos == bbyte) begin
				found = 1;
				stop = 1;
			end else if (sz == 0 || pos + sz > bbyte) begin
				stop = 1;
			end else begin
				has_prev = (pos + sz == bbyte) && hdr_free[pg];
				prev_g = pg;
				pos += sz;
				steps++;
			end
		end
		if (!found)
			return ST_INVALID;
		if (hdr_free[g])
			return ST_DOUBLE_FREE;
		hdr_free[g] = 1'b1;
		hdr_link[g] = '0;
		nb = bbyte + hdr_size[g];
		if (nb < HEAP) begin
			ng = nb / GRAIN;
			if (hdr_free[ng]) begin
				list_unlink(ng);
				hdr_size[g] = hdr_size[g] + hdr_size[ng];
			end
		end
		if (has_prev) begin
			hdr_size[prev_g] = hdr_size[prev_g] + hdr_size[g];
		end else begin
			hdr_link[g] = list_head[9:0];
			list_head = g + 1;
		end
		return ST_OK;
	endfunction

	// Predicts the response of one item and queues it for the driver.
	task automatic queue_item(logic [OP_W-1:0] op, int unsigned req, int unsigned off,
			bit nul);
		heap_item_t it;
		it.op = op;
		it.req = REQ_W'(req);
		it.off = OFF_W'(off);
		it.nul = nul;
		it.uoff = '0;
		if (op == OPER_ALLOC) begin
			heap_alloc(req, it);
			if (it.st == ST_OK)
				live_offs.push_back(it.uoff);
		end else if (nul) begin
			it.st = ST_NULL_IGNORED;
		end else begin
			it.st = heap_release(off);
			if (it.st == ST_OK) begin
				foreach (live_offs[i])
					if (live_offs[i] == off) begin
						live_offs.delete(i);
						break;
					end
				dead_offs.push_back(off);
			end
		end
		pending_q.push_back(it);
	endtask

	// One random item, mostly well-formed allocate/free traffic.
	task automatic queue_random;
		int unsigned r, sz, k;
		r = $urandom_range(99);
		k = $urandom_range(99);
		if (k < 85)
			sz = $urandom_range(256, 1);
		else if (k < 96)
			sz = $urandom_range(1500, 257);
		else
			sz = $urandom_range(4096, 1501);
		if (r < 40 || (r < 78 && live_offs.size() == 0)) begin
			queue_item(OPER_ALLOC, sz, $urandom_range(4095), 1'($urandom_range(1)));
		end else if (r < 78) begin
			queue_item(OPER_FREE, $urandom_range(8191),
				live_offs[$urandom_range(live_offs.size() - 1)], 1'b0);
		end else if (r < 85) begin
			queue_item(OPER_FREE, $urandom_range(8191), $urandom_range(4095), 1'b1);
		end else if (r < 92 && dead_offs.size() > 0) begin
			queue_item(OPER_FREE, 0, dead_offs[$urandom_range(dead_offs.size() - 1)], 1'b0);
		end else if (r < 95) begin
			queue_item(OPER_ALLOC, 0, 0, 1'b0);
		end else begin
			queue_item(OPER_FREE, $urandom_range(8191), $urandom_range(4095), 1'b0);
		end
	endtask

	task automatic wait_drained;
		while (pending_q.size() != 0 || response_q.size() != 0 || req_ch.valid)
			@(negedge clk);
	endtask

	// Request driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.operation <= OPER_ALLOC;
			req_ch.request_bytes <= '0;
			req_ch.free_offset <= '0;
			req_ch.null_pointer <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				response_q.push_back(in_flight);
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					in_flight = pending_q.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.operation <= in_flight.op;
					req_ch.request_bytes <= in_flight.req;
					req_ch.free_offset <= in_flight.off;
					req_ch.null_pointer <= in_flight.nul;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor and ready control.
	always @(posedge clk or negedge arst_n) begin
		heap_item_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			hold_cnt <= 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (response_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("unexpected response: status %0d offset %0d",
							rsp_ch.status, rsp_ch.user_offset);
				end else begin
					want = response_q.pop_front();
					if (rsp_ch.status !== want.st || rsp_ch.user_offset !== want.uoff) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display("mismatch: expected status %0d offset %0d, got %0d %0d",
								want.st, want.uoff, rsp_ch.status, rsp_ch.user_offset);
					end
				end
			end
			// A long hold-off lets the input side back up.
			if (hold_go && !hold_done) begin
				rsp_ch.ready <= 1'b0;
				if (hold_cnt == HOLD_CYCLES)
					hold_done <= 1'b1;
				else
					hold_cnt <= hold_cnt + 1;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= dst_idle_pct);
			end
		end
	end

	// Watchdog on cycles with no handshake on either channel.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else if (arst_n)
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Stimulus sequence.
	initial begin
		err_cnt = 0;
		quiet_cycles = 0;
		hold_go = 0;
		hold_done = 0;
		src_idle_pct = 28;
		dst_idle_pct = 73;
		for (int i = 0; i < GRAN; i++) begin
			hdr_size[i] = '0;
			hdr_free[i] = 1'b0;
			hdr_link[i] = '0;
		end
		hdr_size[0] = 13'(HEAP);
		hdr_free[0] = 1'b1;
		list_head = 1;
		arst_n = 1'b1;
		#0 arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: special cases and field extremes.
		queue_item(OPER_ALLOC, 0, 0, 1'b0);
		queue_item(OPER_ALLOC, 4096, 4095, 1'b1);
		queue_item(OPER_FREE, 8191, 4095, 1'b1);
		queue_item(OPER_FREE, 0, 0, 1'b0);
		queue_item(OPER_FREE, 0, 16, 1'b0);
		queue_item(OPER_FREE, 0, 24, 1'b0);
		queue_item(OPER_ALLOC, 4072, 0, 1'b0);
		queue_item(OPER_ALLOC, 1, 0, 1'b0);
		queue_item(OPER_FREE, 0, 24, 1'b0);
		queue_item(OPER_FREE, 0, 24, 1'b0);
		queue_item(OPER_ALLOC, 1, 0, 1'b0);
		queue_item(OPER_ALLOC, 8, 0, 1'b0);
		queue_item(OPER_ALLOC, 100, 0, 1'b0);
		queue_item(OPER_FREE, 0, 27, 1'b0);
		queue_item(OPER_FREE, 0, 64, 1'b0);
		queue_item(OPER_FREE, 0, 4095, 1'b0);
		queue_item(OPER_FREE, 0, 4088, 1'b0);
		queue_item(OPER_FREE, 0, 56, 1'b0);
		queue_item(OPER_FREE, 0, 24, 1'b0);
		queue_item(OPER_FREE, 0, 88, 1'b0);
		queue_item(OPER_ALLOC, 4073, 0, 1'b0);
		queue_item(OPER_ALLOC, 4072, 0, 1'b0);
		live_offs.delete();
		dead_offs.delete();
		wait_drained();

		repeat (180) queue_random();
		wait_drained();

		src_idle_pct = 73;
		dst_idle_pct = 28;
		repeat (170) queue_random();
		wait_drained();

		// Receiver holds off while the sender keeps offering.
		src_idle_pct = 0;
		dst_idle_pct = 0;
		hold_go = 1;
		repeat (20) queue_random();
		while (!hold_done)
			@(negedge clk);
		hold_go = 0;
		// Sender pauses until every response is back.
		wait_drained();

		repeat (170) queue_random();
		wait_drained();
		repeat (50) @(posedge clk);

		if (err_cnt == 0 && response_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
